### hdl/tti_pkg.sv
package tti_pkg;

    // default saturation point of the character position counter
    localparam longint unsigned MAX_CHARS_DEF = 64'd65535;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned OFFS_W  = 16;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned IDX_W   = 1;
    // value, end_offset, error_code packed and padded to whole bytes
    localparam int unsigned RES_BITS = VALUE_W + OFFS_W + ERR_W;
    localparam int unsigned M_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BASE_SELECT = 1'd0;
    localparam logic [IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    // characters
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_BASE  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic [6:0] {
        PH_WS     = 7'b0000001,
        PH_SIGN   = 7'b0000010,
        PH_ZERO   = 7'b0000100,
        PH_ZERO_X = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_REJECT = 7'b1000000
    } phase_t;

    // parse state carried from one character to the next
    typedef struct packed {
        phase_t               phase;
        logic [VALUE_W-1:0]   acc;
        logic                 neg;
        logic                 ovf;
        logic [BASE_W-1:0]    abase;
    } core_t;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] val;
    } digit_t;

    localparam core_t CORE_CLEAR = '{
        phase: PH_WS,
        acc:   '0,
        neg:   1'b0,
        ovf:   1'b0,
        abase: '0
    };

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic digit_t char_digit(input logic [CHAR_W-1:0] c);
        digit_t r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c inside {[CH_ZERO:CH_NINE]})
            r.val = BASE_W'(c - CH_ZERO);
        else if (c inside {[CH_LO_A:CH_LO_Z]})
            r.val = BASE_W'(c - CH_LO_A) + BASE_DEC;
        else if (c inside {[CH_UP_A:CH_UP_Z]})
            r.val = BASE_W'(c - CH_UP_A) + BASE_DEC;
        else
            r.ok = 1'b0;
        return r;
    endfunction

    function automatic logic base_invalid(input logic [BASE_W-1:0] b);
        return (b == 6'd1) || (b > BASE_MAX);
    endfunction

endpackage

### hdl/tti_step.sv
// Next-state logic for one character: phase decode, base pick and the
// shared multiply-add with overflow detect.
module tti_step #(
    parameter longint unsigned MAX_CHARS = tti_pkg::MAX_CHARS_DEF,
    parameter int unsigned     POS_W     = $clog2(MAX_CHARS + 64'd1)
) (
    input  tti_pkg::core_t                  cur,
    input  logic [POS_W-1:0]                pos_cur,
    input  logic [POS_W-1:0]                end_cur,
    input  logic [tti_pkg::CHAR_W-1:0]      character,
    input  logic [tti_pkg::BASE_W-1:0]      base_select,
    input  logic                            signed_mode,
    output tti_pkg::core_t                  nxt,
    output logic [POS_W-1:0]                pos_nxt,
    output logic [POS_W-1:0]                end_nxt
);

    localparam int unsigned PROD_W = tti_pkg::VALUE_W + tti_pkg::BASE_W;

    tti_pkg::digit_t             dg;
    logic                        start;
    logic                        take;
    logic [tti_pkg::BASE_W-1:0]  tbase;
    logic [PROD_W-1:0]           prod;

    assign dg = tti_pkg::char_digit(character);

    // one multiplier serves every phase that consumes a digit
    assign prod = PROD_W'(cur.acc) * PROD_W'(tbase) + PROD_W'(dg.val);

    always_comb
    begin
        nxt     = cur;
        end_nxt = end_cur;
        pos_nxt = (pos_cur != POS_W'(MAX_CHARS)) ? pos_cur + 1'b1 : pos_cur;
        start   = 1'b0;
        take    = 1'b0;
        tbase   = cur.abase;

        case (cur.phase)
            tti_pkg::PH_WS:
            begin
                if (tti_pkg::is_space(character))
                begin
                    nxt.phase = tti_pkg::PH_WS;
                end
                else if (tti_pkg::is_sign(character))
                begin
                    nxt.neg   = (character == tti_pkg::CH_MINUS);
                    nxt.phase = tti_pkg::PH_SIGN;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            tti_pkg::PH_SIGN:
            begin
                if (signed_mode && (tti_pkg::is_sign(character) ||
                                    tti_pkg::is_space(character)))
                    nxt.phase = tti_pkg::PH_REJECT;
                else
                    start = 1'b1;
            end
            tti_pkg::PH_ZERO:
            begin
                if (character == tti_pkg::CH_LO_X || character == tti_pkg::CH_UP_X)
                begin
                    nxt.phase = tti_pkg::PH_ZERO_X;
                end
                else
                begin
                    tbase = (base_select == tti_pkg::BASE_AUTO) ? tti_pkg::BASE_OCT
                                                                : base_select;
                    take  = 1'b1;
                end
            end
            tti_pkg::PH_ZERO_X:
            begin
                if (dg.ok && dg.val < tti_pkg::BASE_HEX)
                begin
                    tbase = tti_pkg::BASE_HEX;
                    take  = 1'b1;
                end
                else
                begin
                    // "0x" with no hex digit: the zero stands, x ends it
                    nxt.abase = (base_select == tti_pkg::BASE_AUTO) ? tti_pkg::BASE_OCT
                                                                    : base_select;
                    nxt.phase = tti_pkg::PH_DONE;
                end
            end
            tti_pkg::PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
                nxt.phase = cur.phase;
            end
        endcase

        if (start)
        begin
            if ((base_select == tti_pkg::BASE_AUTO || base_select == tti_pkg::BASE_HEX) &&
                character == tti_pkg::CH_ZERO)
            begin
                nxt.acc   = '0;
                end_nxt   = pos_nxt;
                nxt.phase = tti_pkg::PH_ZERO;
            end
            else
            begin
                tbase = (base_select == tti_pkg::BASE_AUTO) ? tti_pkg::BASE_DEC
                                                            : base_select;
                take  = 1'b1;
            end
        end

        if (take)
        begin
            nxt.abase = tbase;
            if (tbase < tti_pkg::BASE_MIN || tbase > tti_pkg::BASE_MAX ||
                !dg.ok || dg.val >= tbase)
            begin
                nxt.phase = tti_pkg::PH_DONE;
            end
            else
            begin
                nxt.phase = tti_pkg::PH_DIGITS;
                end_nxt   = pos_nxt;
                if (!cur.ovf)
                begin
                    if (prod[PROD_W-1:tti_pkg::VALUE_W] != '0)
                    begin
                        nxt.ovf = 1'b1;
                        nxt.acc = '1;
                    end
                    else
                    begin
                        nxt.acc = prod[tti_pkg::VALUE_W-1:0];
                    end
                end
            end
        end
    end

endmodule

### hdl/text_to_integer_parser_unit.sv
// Streaming text-to-integer parser (strtoull / strtoll rules). One byte of
// text enters per request on the s_ side; the byte with s_tlast high closes
// the string and yields exactly one result on the m_ side: the 64-bit value,
// the offset just past the last digit (0 if none) and an error code (0 none,
// 1 invalid base, 2 out of range). Leading whitespace is skipped, one sign is
// taken, and with base_select 0 the radix is detected (0x/0X + hex digit ->
// 16, leading 0 -> 8, else 10). Overflow saturates: all ones unsigned, the
// signed min/max in signed mode. Rate: one character per clock, sustained,
// with no gaps between strings, unless m_tready stalls the result stages;
// the limit is the accumulator recurrence, a 64x6 multiply-add with overflow
// detect that closes on itself each cycle. A result is latched as the final
// parse state in stage 1, then signed/clamped into the stage 2 register that
// drives m_tvalid. Configuration (cfg_index 0 = base_select, 1 = signed_mode)
// may be written only while the unit is idle; the values in force at the last
// byte govern the result. No clearing pass after reset.
module text_to_integer_parser_unit #(
    parameter longint unsigned MAX_CHARS = tti_pkg::MAX_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tti_pkg::CHAR_W-1:0]       s_tdata,   // [7:0] character
    input  logic                             s_tlast,   // last byte of string
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tti_pkg::M_DATA_W-1:0]     m_tdata,   // [63:0] value,
                                                        // [79:64] end_offset,
                                                        // [81:80] error_code,
                                                        // [87:82] zero
    // configuration writes
    input  logic                             cfg_we,
    input  logic [tti_pkg::IDX_W-1:0]        cfg_index,
    input  logic [tti_pkg::BASE_W-1:0]       cfg_data
);

    localparam int unsigned POS_W = $clog2(MAX_CHARS + 64'd1);
    localparam int unsigned EXT_W = (POS_W > tti_pkg::OFFS_W) ? POS_W : tti_pkg::OFFS_W;
    localparam int unsigned VW    = tti_pkg::VALUE_W;

    // configuration
    logic [tti_pkg::BASE_W-1:0]  base_select_reg;
    logic                        signed_mode_reg;

    // running parse state
    tti_pkg::core_t              core_reg, core_step;
    logic [POS_W-1:0]            pos_reg, pos_step;
    logic [POS_W-1:0]            end_reg, end_step;

    // stage 1: parse state latched at the last byte
    logic                        snap_valid_reg;
    logic [VW-1:0]               snap_acc_reg;
    logic                        snap_neg_reg;
    logic                        snap_ovf_reg;
    logic                        snap_reject_reg;
    logic [tti_pkg::BASE_W-1:0]  snap_base_reg;
    logic                        snap_signed_reg;
    logic [POS_W-1:0]            snap_end_reg;

    // stage 2: result register
    logic                        out_valid_reg;
    logic [VW-1:0]               out_value_reg, out_value_next;
    logic [tti_pkg::OFFS_W-1:0]  out_end_reg, out_end_next;
    tti_pkg::err_t               out_err_reg, out_err_next;

    logic                        in_fire;
    logic                        out_free;
    logic                        snap_free;
    logic [VW-1:0]               neg_acc;
    logic                        mag_too_big;
    logic [EXT_W-1:0]            end_ext;

    // the result register frees when empty or taken; stage 1 moves on then
    assign out_free  = !out_valid_reg || m_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign s_tready  = snap_free;
    assign in_fire   = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = tti_pkg::M_DATA_W'({out_err_reg, out_end_reg, out_value_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg <= tti_pkg::BASE_AUTO;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tti_pkg::REG_BASE_SELECT: base_select_reg <= cfg_data;
                tti_pkg::REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:                  signed_mode_reg <= signed_mode_reg;
            endcase
        end
    end

    tti_step #(
        .MAX_CHARS (MAX_CHARS),
        .POS_W     (POS_W)
    ) u_step (
        .cur         (core_reg),
        .pos_cur     (pos_reg),
        .end_cur     (end_reg),
        .character   (s_tdata),
        .base_select (base_select_reg),
        .signed_mode (signed_mode_reg),
        .nxt         (core_step),
        .pos_nxt     (pos_step),
        .end_nxt     (end_step)
    );

    // parse state: advances per byte, clears after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg <= tti_pkg::CORE_CLEAR;
            pos_reg  <= '0;
            end_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (s_tlast)
            begin
                core_reg <= tti_pkg::CORE_CLEAR;
                pos_reg  <= '0;
                end_reg  <= '0;
            end
            else
            begin
                core_reg <= core_step;
                pos_reg  <= pos_step;
                end_reg  <= end_step;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_free)
            snap_valid_reg <= in_fire && s_tlast;
    end

    // stage 1 payload: config sampled with the last byte
    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            snap_acc_reg    <= core_step.acc;
            snap_neg_reg    <= core_step.neg;
            snap_ovf_reg    <= core_step.ovf;
            snap_reject_reg <= (core_step.phase == tti_pkg::PH_REJECT);
            snap_base_reg   <= base_select_reg;
            snap_signed_reg <= signed_mode_reg;
            snap_end_reg    <= end_step;
        end
    end

    // sign, clamp and error code
    assign neg_acc = VW'(0) - snap_acc_reg;
    // signed limit: 2^63 for negative, 2^63-1 for positive
    assign mag_too_big = snap_neg_reg ? (snap_acc_reg[VW-1] && (|snap_acc_reg[VW-2:0]))
                                      : snap_acc_reg[VW-1];
    assign end_ext = EXT_W'(snap_end_reg);

    always_comb
    begin
        out_end_next = (end_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                     : end_ext[tti_pkg::OFFS_W-1:0];
        out_value_next = snap_neg_reg ? neg_acc : snap_acc_reg;
        out_err_next   = tti_pkg::ERR_NONE;
        if (snap_reject_reg)
        begin
            // sign followed by a sign or whitespace in signed mode
            out_value_next = '0;
            out_end_next   = '0;
        end
        else if (tti_pkg::base_invalid(snap_base_reg))
        begin
            out_value_next = '0;
            out_end_next   = '0;
            out_err_next   = tti_pkg::ERR_BASE;
        end
        else if (!snap_signed_reg)
        begin
            if (snap_ovf_reg)
            begin
                out_value_next = '1;
                out_err_next   = tti_pkg::ERR_RANGE;
            end
        end
        else if (snap_ovf_reg || mag_too_big)
        begin
            // signed minimum when negative, signed maximum otherwise
            out_value_next = {snap_neg_reg, {(VW-1){!snap_neg_reg}}};
            out_err_next   = tti_pkg::ERR_RANGE;
        end
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && snap_valid_reg)
        begin
            out_value_reg <= out_value_next;
            out_end_reg   <= out_end_next;
            out_err_reg   <= out_err_next;
        end
    end

    // the string's state is wiped once its last byte is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (core_reg.phase == tti_pkg::PH_WS) &&
                                 (pos_reg == '0) && !core_reg.ovf)
        else $error("parse state not cleared after last byte");

    // a last byte always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> snap_valid_reg)
        else $error("last byte lost before result stage");

    // invalid base reports zero value and zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg == tti_pkg::ERR_BASE) |->
            (out_value_reg == '0) && (out_end_reg == '0))
        else $error("invalid base result carries data");

    // a range error needs at least one digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg == tti_pkg::ERR_RANGE) |-> (out_end_reg != '0))
        else $error("range error without digits");

endmodule
